FILE: hw/rtl/nfra_pkg.sv
// shared types, codes and sizing helpers for the next-fit ring slot allocator
package nfra_pkg;

    localparam int DEF_MAX_SLOTS        = 1024;
    localparam int DEF_DESCRIPTOR_BYTES = 16;
    localparam int DEF_TAG_BITS         = 16;

    // occupancy bitmap is kept as 32-bit words
    localparam int OCC_WORD_BITS = 32;
    localparam int OCC_BIT_W     = 5;

    localparam int NUM_SLOTS_W = 11;
    localparam int RING_BASE_W = 32;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [NUM_SLOTS_W-1:0] RESET_NUM_SLOTS = 11'd1024;
    localparam logic [RING_BASE_W-1:0] RESET_RING_BASE = 32'd0;

    typedef enum logic [0:0] {
        REG_NUM_SLOTS = 1'b0,
        REG_RING_BASE = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_LOOKUP  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef struct packed {
        logic [RING_BASE_W-1:0] ring_base;
        logic [NUM_SLOTS_W-1:0] num_slots;
    } t_cfg;

    function automatic int occ_words(input int max_slots);
        return (max_slots + OCC_WORD_BITS - 1) / OCC_WORD_BITS;
    endfunction

    function automatic int word_idx_w(input int max_slots);
        int nw;
        nw = occ_words(max_slots);
        return (nw > 1) ? $clog2(nw) : 1;
    endfunction

    // index of the lowest set bit
    function automatic logic [OCC_BIT_W-1:0] first_set(input logic [OCC_WORD_BITS-1:0] v);
        logic [OCC_BIT_W-1:0] r;
        r = '0;
        for (int i = OCC_WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = OCC_BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/next_fit_ring_slot_allocator_core.sv
// top level: register port, sequencer and the two state memories
//
// Commands enter on the s_axis beat channel: tuser carries the command
// (allocate, lookup, release, clear), tdata the owner tag and slot number.
// Each command gives exactly one result beat on m_axis: tuser carries the
// status and tag-present flag, tdata the slot, descriptor address and tag.
// One command is worked at a time. Lookup and release pass through a lookup
// state and then the push state; an index out of range, a clear and an
// allocate with no active slots go straight to push. Allocate reads the
// occupancy bitmap one 32-slot word per cycle starting at the word of the
// next-fit hint, evaluates each word once its read returns, and reports a
// full ring after the scan wraps back onto the start word. The result sits in
// its own output register: a stalled receiver holds that beat while the next
// command is accepted and worked, and only a second finished result waits for
// the register to drain. Reset frees every slot at once (per-word valid bits),
// zeroes the hint and loads num_slots = 1024, ring_base = 0. Clear frees every
// slot at once and leaves the hint. Registers are to be written over the APB
// port only while idle; the block itself does not enforce this.
module next_fit_ring_slot_allocator_core #(
    parameter int MAX_SLOTS        = nfra_pkg::DEF_MAX_SLOTS,
    parameter int DESCRIPTOR_BYTES = nfra_pkg::DEF_DESCRIPTOR_BYTES,
    parameter int TAG_BITS         = nfra_pkg::DEF_TAG_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nfra_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [nfra_pkg::APB_DATA_W-1:0] pwdata,
    output logic [nfra_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // owner_tag, slot_number
    input  logic [1:0]                      s_axis_tuser,  // command
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [63:0]                     m_axis_tdata,  // result_slot, descriptor_address,
                                                           // result_tag
    output logic [2:0]                      m_axis_tuser   // status, tag_present
);

    localparam int NW     = nfra_pkg::occ_words(MAX_SLOTS);
    localparam int WIW    = nfra_pkg::word_idx_w(MAX_SLOTS);
    localparam int SLOT_W = $clog2(MAX_SLOTS);

    logic [nfra_pkg::NUM_SLOTS_W-1:0] r_num_slots;
    logic [nfra_pkg::RING_BASE_W-1:0] r_ring_base;
    nfra_pkg::t_cfg                   w_cfg;
    nfra_pkg::t_reg_idx               w_reg;
    logic                             w_wr;

    logic                               w_occ_clr;
    logic                               w_occ_rd_en;
    logic [WIW-1:0]                     w_occ_rd_addr;
    logic [nfra_pkg::OCC_WORD_BITS-1:0] w_occ_rd_data;
    logic                               w_occ_wr_en;
    logic [WIW-1:0]                     w_occ_wr_addr;
    logic [nfra_pkg::OCC_WORD_BITS-1:0] w_occ_wr_data;
    logic                               w_tag_rd_en;
    logic [SLOT_W-1:0]                  w_tag_rd_addr;
    logic [TAG_BITS-1:0]                w_tag_rd_data;
    logic                               w_tag_wr_en;
    logic [SLOT_W-1:0]                  w_tag_wr_addr;
    logic [TAG_BITS-1:0]                w_tag_wr_data;

    assign w_reg  = nfra_pkg::t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_slots <= nfra_pkg::RESET_NUM_SLOTS;
            r_ring_base <= nfra_pkg::RESET_RING_BASE;
        end else if (w_wr) begin
            unique case (w_reg)
                nfra_pkg::REG_NUM_SLOTS: r_num_slots <= pwdata[nfra_pkg::NUM_SLOTS_W-1:0];
                nfra_pkg::REG_RING_BASE: r_ring_base <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            nfra_pkg::REG_NUM_SLOTS: prdata = nfra_pkg::APB_DATA_W'(r_num_slots);
            nfra_pkg::REG_RING_BASE: prdata = r_ring_base;
        endcase
    end

    assign w_cfg.num_slots = r_num_slots;
    assign w_cfg.ring_base = r_ring_base;

    nfra_ctrl #(
        .MAX_SLOTS        (MAX_SLOTS),
        .DESCRIPTOR_BYTES (DESCRIPTOR_BYTES),
        .TAG_BITS         (TAG_BITS),
        .WIW              (WIW),
        .SLOT_W           (SLOT_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .o_occ_clr      (w_occ_clr),
        .o_occ_rd_en    (w_occ_rd_en),
        .o_occ_rd_addr  (w_occ_rd_addr),
        .i_occ_rd_data  (w_occ_rd_data),
        .o_occ_wr_en    (w_occ_wr_en),
        .o_occ_wr_addr  (w_occ_wr_addr),
        .o_occ_wr_data  (w_occ_wr_data),
        .o_tag_rd_en    (w_tag_rd_en),
        .o_tag_rd_addr  (w_tag_rd_addr),
        .i_tag_rd_data  (w_tag_rd_data),
        .o_tag_wr_en    (w_tag_wr_en),
        .o_tag_wr_addr  (w_tag_wr_addr),
        .o_tag_wr_data  (w_tag_wr_data)
    );

    nfra_occ_ram #(
        .DEPTH  (NW),
        .ADDR_W (WIW)
    ) u_occ_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (w_occ_clr),
        .i_rd_en   (w_occ_rd_en),
        .i_rd_addr (w_occ_rd_addr),
        .o_rd_data (w_occ_rd_data),
        .i_wr_en   (w_occ_wr_en),
        .i_wr_addr (w_occ_wr_addr),
        .i_wr_data (w_occ_wr_data)
    );

    nfra_tag_ram #(
        .DEPTH  (MAX_SLOTS),
        .ADDR_W (SLOT_W),
        .DATA_W (TAG_BITS)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_tag_rd_en),
        .i_rd_addr (w_tag_rd_addr),
        .o_rd_data (w_tag_rd_data),
        .i_wr_en   (w_tag_wr_en),
        .i_wr_addr (w_tag_wr_addr),
        .i_wr_data (w_tag_wr_data)
    );

endmodule

FILE: hw/rtl/nfra_occ_ram.sv
// occupancy bitmap memory with per-word valid bits for instant clear
module nfra_occ_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_clr,
    input  logic                               i_rd_en,
    input  logic [ADDR_W-1:0]                  i_rd_addr,
    output logic [nfra_pkg::OCC_WORD_BITS-1:0] o_rd_data,
    input  logic                               i_wr_en,
    input  logic [ADDR_W-1:0]                  i_wr_addr,
    input  logic [nfra_pkg::OCC_WORD_BITS-1:0] i_wr_data
);

    logic [nfra_pkg::OCC_WORD_BITS-1:0] r_mem [DEPTH];
    logic [nfra_pkg::OCC_WORD_BITS-1:0] r_q;
    logic [DEPTH-1:0]                   r_vld;
    logic                               r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q     <= r_mem[i_rd_addr];
            r_q_vld <= r_vld[i_rd_addr];
        end
    end

    // a word never written since reset or clear reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_clr) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_q_vld ? r_q : '0;

endmodule

FILE: hw/rtl/nfra_tag_ram.sv
// owner tag memory, one port write, one registered read
module nfra_tag_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

FILE: hw/rtl/nfra_ctrl.sv
// command sequencer: bitmap scan, read-modify-write and result register
module nfra_ctrl #(
    parameter int MAX_SLOTS        = nfra_pkg::DEF_MAX_SLOTS,
    parameter int DESCRIPTOR_BYTES = nfra_pkg::DEF_DESCRIPTOR_BYTES,
    parameter int TAG_BITS         = nfra_pkg::DEF_TAG_BITS,
    parameter int WIW              = nfra_pkg::word_idx_w(MAX_SLOTS),
    parameter int SLOT_W           = $clog2(MAX_SLOTS)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  nfra_pkg::t_cfg                     i_cfg,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [31:0]                        s_axis_tdata,
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [63:0]                        m_axis_tdata,
    output logic [2:0]                         m_axis_tuser,
    output logic                               o_occ_clr,
    output logic                               o_occ_rd_en,
    output logic [WIW-1:0]                     o_occ_rd_addr,
    input  logic [nfra_pkg::OCC_WORD_BITS-1:0] i_occ_rd_data,
    output logic                               o_occ_wr_en,
    output logic [WIW-1:0]                     o_occ_wr_addr,
    output logic [nfra_pkg::OCC_WORD_BITS-1:0] o_occ_wr_data,
    output logic                               o_tag_rd_en,
    output logic [SLOT_W-1:0]                  o_tag_rd_addr,
    input  logic [TAG_BITS-1:0]                i_tag_rd_data,
    output logic                               o_tag_wr_en,
    output logic [SLOT_W-1:0]                  o_tag_wr_addr,
    output logic [TAG_BITS-1:0]                o_tag_wr_data
);

    localparam int BW    = nfra_pkg::OCC_BIT_W;
    localparam int WB    = nfra_pkg::OCC_WORD_BITS;
    localparam int POS_W = WIW + BW;
    localparam int CMP_W = POS_W + 1;
    localparam int KW    = WIW + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LOOK = 4'b0100,
        S_PUSH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [POS_W-1:0] r_hint, n_hint;
    logic             r_iss_more, n_iss_more;
    logic             r_ev_v, n_ev_v;
    logic             r_o_valid, n_o_valid;

    logic [POS_W-1:0]        r_start, n_start;
    logic [WIW-1:0]          r_lw, n_lw;
    logic [WIW-1:0]          r_iss_word, n_iss_word;
    logic [KW-1:0]           r_iss_k, n_iss_k;
    logic [WIW-1:0]          r_ev_word, n_ev_word;
    logic                    r_ev_first, n_ev_first;
    logic                    r_ev_last, n_ev_last;
    logic [TAG_BITS-1:0]     r_tag, n_tag;
    logic [POS_W-1:0]        r_idx, n_idx;
    logic                    r_rel, n_rel;
    nfra_pkg::t_status       r_res_status, n_res_status;
    logic [9:0]              r_res_slot, n_res_slot;
    logic [POS_W-1:0]        r_res_pos, n_res_pos;
    logic [15:0]             r_res_tag, n_res_tag;
    logic                    r_res_present, n_res_present;
    logic                    r_res_addr_en, n_res_addr_en;
    nfra_pkg::t_status       r_o_status, n_o_status;
    logic [9:0]              r_o_slot, n_o_slot;
    logic [31:0]             r_o_addr, n_o_addr;
    logic [15:0]             r_o_tag, n_o_tag;
    logic                    r_o_present, n_o_present;

    logic [CMP_W-1:0] w_n;
    logic [CMP_W-1:0] w_nm1;
    logic [WIW-1:0]   w_lw;
    logic [POS_W-1:0] w_start;
    logic             w_accept;
    nfra_pkg::t_cmd   w_cmd;
    logic [15:0]      w_tag_in;
    logic [9:0]       w_idx;
    logic [POS_W-1:0] w_idx_pos;
    logic             w_idx_oor;
    logic [WB-1:0]    w_cand;
    logic             w_hit;
    logic [BW-1:0]    w_bit;
    logic [POS_W-1:0] w_found;
    logic [CMP_W-1:0] w_found_nx;
    logic             w_look_occ;
    logic             w_out_free;
    logic [31:0]      w_addr;

    // active slot count, saturated at the ring's physical size
    assign w_n = (32'(i_cfg.num_slots) > 32'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS)
                                                          : CMP_W'(i_cfg.num_slots);
    assign w_nm1   = w_n - CMP_W'(1);
    assign w_lw    = WIW'(w_nm1 >> BW);
    assign w_start = (CMP_W'(r_hint) >= w_n) ? '0 : r_hint;

    assign w_accept  = s_axis_tvalid && (r_state == S_IDLE);
    assign w_cmd     = nfra_pkg::t_cmd'(s_axis_tuser);
    assign w_tag_in  = s_axis_tdata[15:0];
    assign w_idx     = s_axis_tdata[25:16];
    assign w_idx_pos = POS_W'(w_idx);
    assign w_idx_oor = 32'(w_idx) >= 32'(w_n);

    // free slots of the evaluated word that lie inside this visit's window
    always_comb begin
        for (int b = 0; b < WB; b++) begin
            logic [POS_W-1:0] pos;
            pos = {r_ev_word, BW'(b)};
            w_cand[b] = !i_occ_rd_data[b] && (CMP_W'(pos) < w_n)
                        && (!r_ev_first || (pos >= r_start))
                        && (!r_ev_last || (pos < r_start));
        end
    end

    assign w_hit      = (r_state == S_SCAN) && r_ev_v && (|w_cand);
    assign w_bit      = nfra_pkg::first_set(w_cand);
    assign w_found    = {r_ev_word, w_bit};
    assign w_found_nx = CMP_W'(w_found) + CMP_W'(1);
    assign w_look_occ = i_occ_rd_data[r_idx[BW-1:0]];
    assign w_out_free = !r_o_valid || m_axis_tready;
    assign w_addr     = r_res_addr_en ? (i_cfg.ring_base
                        + 32'(r_res_pos) * 32'(DESCRIPTOR_BYTES)) : '0;

    // memory ports
    always_comb begin
        o_occ_clr     = w_accept && (w_cmd == nfra_pkg::CMD_CLEAR);
        o_tag_rd_en   = w_accept && !w_idx_oor
                        && ((w_cmd == nfra_pkg::CMD_LOOKUP) || (w_cmd == nfra_pkg::CMD_RELEASE));
        o_tag_rd_addr = SLOT_W'(w_idx_pos);
        o_occ_rd_en   = o_tag_rd_en || ((r_state == S_SCAN) && r_iss_more);
        o_occ_rd_addr = (r_state == S_SCAN) ? r_iss_word : w_idx_pos[POS_W-1:BW];
        o_occ_wr_en   = w_hit || ((r_state == S_LOOK) && r_rel && w_look_occ);
        o_occ_wr_addr = (r_state == S_SCAN) ? r_ev_word : r_idx[POS_W-1:BW];
        o_occ_wr_data = (r_state == S_SCAN) ? (i_occ_rd_data | (WB'(1) << w_bit))
                                            : (i_occ_rd_data & ~(WB'(1) << r_idx[BW-1:0]));
        o_tag_wr_en   = w_hit;
        o_tag_wr_addr = SLOT_W'(w_found);
        o_tag_wr_data = r_tag;
    end

    always_comb begin
        n_state       = r_state;
        n_hint        = r_hint;
        n_iss_more    = r_iss_more;
        n_ev_v        = r_ev_v;
        n_o_valid     = r_o_valid;
        n_start       = r_start;
        n_lw          = r_lw;
        n_iss_word    = r_iss_word;
        n_iss_k       = r_iss_k;
        n_ev_word     = r_ev_word;
        n_ev_first    = r_ev_first;
        n_ev_last     = r_ev_last;
        n_tag         = r_tag;
        n_idx         = r_idx;
        n_rel         = r_rel;
        n_res_status  = r_res_status;
        n_res_slot    = r_res_slot;
        n_res_pos     = r_res_pos;
        n_res_tag     = r_res_tag;
        n_res_present = r_res_present;
        n_res_addr_en = r_res_addr_en;
        n_o_status    = r_o_status;
        n_o_slot      = r_o_slot;
        n_o_addr      = r_o_addr;
        n_o_tag       = r_o_tag;
        n_o_present   = r_o_present;

        if (r_o_valid && m_axis_tready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_status  = nfra_pkg::ST_OK;
                    n_res_slot    = '0;
                    n_res_pos     = '0;
                    n_res_tag     = '0;
                    n_res_present = 1'b0;
                    n_res_addr_en = 1'b0;
                    unique case (w_cmd)
                        nfra_pkg::CMD_ALLOC: begin
                            if (w_n == '0) begin
                                n_res_status = nfra_pkg::ST_NO_FREE;
                                n_state      = S_PUSH;
                            end else begin
                                n_start    = w_start;
                                n_lw       = w_lw;
                                n_iss_word = w_start[POS_W-1:BW];
                                n_iss_k    = '0;
                                n_iss_more = 1'b1;
                                n_ev_v     = 1'b0;
                                n_tag      = TAG_BITS'(w_tag_in);
                                n_state    = S_SCAN;
                            end
                        end
                        nfra_pkg::CMD_CLEAR: begin
                            n_state = S_PUSH;
                        end
                        nfra_pkg::CMD_LOOKUP, nfra_pkg::CMD_RELEASE: begin
                            n_res_slot = w_idx;
                            if (w_idx_oor) begin
                                n_res_status = nfra_pkg::ST_RANGE;
                                n_state      = S_PUSH;
                            end else begin
                                n_idx   = w_idx_pos;
                                n_rel   = (w_cmd == nfra_pkg::CMD_RELEASE);
                                n_state = S_LOOK;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // one word read issued per cycle, evaluated in the cycle after its issue
                if (r_iss_more) begin
                    n_ev_v     = 1'b1;
                    n_ev_word  = r_iss_word;
                    n_ev_first = (r_iss_k == '0);
                    n_ev_last  = (r_iss_k == (KW'(r_lw) + KW'(1)));
                    n_iss_word = (r_iss_word == r_lw) ? '0 : r_iss_word + WIW'(1);
                    n_iss_k    = r_iss_k + KW'(1);
                    n_iss_more = (r_iss_k != (KW'(r_lw) + KW'(1)));
                end else begin
                    n_ev_v = 1'b0;
                end
                if (w_hit) begin
                    n_res_status  = nfra_pkg::ST_OK;
                    n_res_slot    = 10'(w_found);
                    n_res_pos     = w_found;
                    n_res_tag     = 16'(r_tag);
                    n_res_present = 1'b1;
                    n_res_addr_en = 1'b1;
                    n_hint        = (w_found_nx >= w_n) ? '0 : POS_W'(w_found_nx);
                    n_ev_v        = 1'b0;
                    n_iss_more    = 1'b0;
                    n_state       = S_PUSH;
                end else if (r_ev_v && r_ev_last) begin
                    // wrapped back onto the start word, ring is full
                    n_res_status = nfra_pkg::ST_NO_FREE;
                    n_ev_v       = 1'b0;
                    n_iss_more   = 1'b0;
                    n_state      = S_PUSH;
                end
            end
            S_LOOK: begin
                n_res_pos     = r_idx;
                n_res_addr_en = 1'b1;
                if (w_look_occ) begin
                    n_res_status  = nfra_pkg::ST_OK;
                    n_res_tag     = 16'(i_tag_rd_data);
                    n_res_present = 1'b1;
                end else begin
                    n_res_status = nfra_pkg::ST_EMPTY;
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_status  = r_res_status;
                    n_o_slot    = r_res_slot;
                    n_o_addr    = w_addr;
                    n_o_tag     = r_res_tag;
                    n_o_present = r_res_present;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_hint     <= '0;
            r_iss_more <= 1'b0;
            r_ev_v     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_hint     <= n_hint;
            r_iss_more <= n_iss_more;
            r_ev_v     <= n_ev_v;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start       <= n_start;
        r_lw          <= n_lw;
        r_iss_word    <= n_iss_word;
        r_iss_k       <= n_iss_k;
        r_ev_word     <= n_ev_word;
        r_ev_first    <= n_ev_first;
        r_ev_last     <= n_ev_last;
        r_tag         <= n_tag;
        r_idx         <= n_idx;
        r_rel         <= n_rel;
        r_res_status  <= n_res_status;
        r_res_slot    <= n_res_slot;
        r_res_pos     <= n_res_pos;
        r_res_tag     <= n_res_tag;
        r_res_present <= n_res_present;
        r_res_addr_en <= n_res_addr_en;
        r_o_status    <= n_o_status;
        r_o_slot      <= n_o_slot;
        r_o_addr      <= n_o_addr;
        r_o_tag       <= n_o_tag;
        r_o_present   <= n_o_present;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {6'b0, r_o_tag, r_o_addr, r_o_slot};
    assign m_axis_tuser  = {r_o_present, r_o_status};

endmodule

FILE: tb/next_fit_ring_slot_allocator_core_tb.sv
// testbench for the next-fit ring slot allocator: directed, random and backpressure tests
module next_fit_ring_slot_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SLOTS      = nfra_pkg::DEF_MAX_SLOTS;
    localparam int DESC_BYTES     = nfra_pkg::DEF_DESCRIPTOR_BYTES;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RECENT_DEPTH   = 64;

    typedef struct {
        nfra_pkg::t_status status;
        logic [9:0]        slot;
        logic [31:0]       addr;
        logic [15:0]       tag;
        logic              present;
    } t_reply;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [nfra_pkg::APB_ADDR_W-1:0] paddr;
    logic [nfra_pkg::APB_DATA_W-1:0] pwdata;
    logic [nfra_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [31:0]                     s_axis_tdata;  // owner_tag, slot_number
    logic [1:0]                      s_axis_tuser;  // command
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [63:0]                     m_axis_tdata;  // result_slot, descriptor_address, result_tag
    logic [2:0]                      m_axis_tuser;  // status, tag_present

    // predictor state
    bit                    slot_busy [MAX_SLOTS];
    logic [15:0]           slot_owner [MAX_SLOTS];
    int unsigned           fit_hint;
    logic [10:0]           cfg_slots;
    logic [31:0]           cfg_base;

    t_reply                pending_replies [$];
    logic [9:0]            recent_slots [$];

    int                    mismatches;
    int                    tx_idle_pct;
    int                    rx_idle_pct;
    int                    rx_hold_left;
    int                    quiet_cycles;

    next_fit_ring_slot_allocator_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned active_slots();
        return (cfg_slots > MAX_SLOTS) ? MAX_SLOTS : cfg_slots;
    endfunction

    function automatic logic [31:0] slot_addr(input int unsigned slot);
        return cfg_base + 32'(slot) * 32'(DESC_BYTES);
    endfunction

    // works out the reply to one accepted command and updates the slot state
    task automatic predict_reply(input nfra_pkg::t_cmd cmd, input logic [15:0] tag,
                                 input logic [9:0] idx);
        t_reply      r;
        int unsigned n;
        int unsigned pos;
        n = active_slots();
        r = '{nfra_pkg::ST_OK, 10'd0, 32'd0, 16'd0, 1'b0};
        case (cmd)
            nfra_pkg::CMD_ALLOC: begin
                r.status = nfra_pkg::ST_NO_FREE;
                pos = (fit_hint >= n) ? 0 : fit_hint;
                for (int k = 0; k < n; k++) begin
                    if (!slot_busy[pos]) begin
                        slot_busy[pos] = 1'b1;
                        slot_owner[pos] = tag;
                        fit_hint = (pos + 1 >= n) ? 0 : pos + 1;
                        r = '{nfra_pkg::ST_OK, pos[9:0], slot_addr(pos), tag, 1'b1};
                        recent_slots.push_back(pos[9:0]);
                        if (recent_slots.size() > RECENT_DEPTH) begin
                            void'(recent_slots.pop_front());
                        end
                        break;
                    end
                    pos = (pos + 1 >= n) ? 0 : pos + 1;
                end
            end
            nfra_pkg::CMD_CLEAR: begin
                slot_busy = '{default: 1'b0};
            end
            default: begin
                if (idx >= n) begin
                    r = '{nfra_pkg::ST_RANGE, idx, 32'd0, 16'd0, 1'b0};
                end else if (!slot_busy[idx]) begin
                    r = '{nfra_pkg::ST_EMPTY, idx, slot_addr(idx), 16'd0, 1'b0};
                end else begin
                    r = '{nfra_pkg::ST_OK, idx, slot_addr(idx), slot_owner[idx], 1'b1};
                    if (cmd == nfra_pkg::CMD_RELEASE) begin
                        slot_busy[idx] = 1'b0;
                    end
                end
            end
        endcase
        pending_replies.push_back(r);
    endtask

    // valid is left high after the beat, so back-to-back commands keep it high unless a random idle drops it
    task automatic send_command(input nfra_pkg::t_cmd cmd, input logic [15:0] tag,
                                input logic [9:0] idx);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(99) < tx_idle_pct) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                break;
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'd0, idx, tag};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_reply(cmd, tag, idx);
    endtask

    task automatic write_reg(input nfra_pkg::t_reg_idx r, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= nfra_pkg::APB_ADDR_W'(4 * int'(r));
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (r == nfra_pkg::REG_NUM_SLOTS) begin
            cfg_slots = value[10:0];
        end else begin
            cfg_base = value;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_ring(input logic [31:0] slots, input logic [31:0] base);
        wait_idle();
        write_reg(nfra_pkg::REG_NUM_SLOTS, slots);
        write_reg(nfra_pkg::REG_RING_BASE, base);
    endtask

    // reset config: empty lookups, alloc at tag extremes, release, next-fit order, clear
    task automatic test_basic_ops();
        send_command(nfra_pkg::CMD_LOOKUP, 16'h0000, 10'd0);
        send_command(nfra_pkg::CMD_LOOKUP, 16'h0000, 10'd1023);
        send_command(nfra_pkg::CMD_ALLOC, 16'h0000, 10'd0);
        send_command(nfra_pkg::CMD_ALLOC, 16'hffff, 10'd1023);
        send_command(nfra_pkg::CMD_LOOKUP, 16'h0000, 10'd1);
        send_command(nfra_pkg::CMD_RELEASE, 16'hffff, 10'd0);
        send_command(nfra_pkg::CMD_RELEASE, 16'h0000, 10'd0);
        send_command(nfra_pkg::CMD_ALLOC, 16'h1234, 10'd0);
        send_command(nfra_pkg::CMD_CLEAR, 16'hffff, 10'd1023);
        send_command(nfra_pkg::CMD_LOOKUP, 16'h0000, 10'd1);
    endtask

    // hint beyond the shrunk ring restarts at 0, full ring, address wrap, out of range
    task automatic test_small_ring();
        set_ring(32'd3, 32'hffff_fff0);
        send_command(nfra_pkg::CMD_ALLOC, 16'h00a1, 10'd0);
        send_command(nfra_pkg::CMD_ALLOC, 16'h00a2, 10'd0);
        send_command(nfra_pkg::CMD_ALLOC, 16'h00a3, 10'd0);
        send_command(nfra_pkg::CMD_ALLOC, 16'h00a4, 10'd0);
        send_command(nfra_pkg::CMD_LOOKUP, 16'h0000, 10'd3);
        send_command(nfra_pkg::CMD_LOOKUP, 16'h0000, 10'd1023);
        send_command(nfra_pkg::CMD_RELEASE, 16'h0000, 10'd1);
        send_command(nfra_pkg::CMD_ALLOC, 16'h00a5, 10'd0);
        send_command(nfra_pkg::CMD_CLEAR, 16'h0000, 10'd0);
    endtask

    task automatic test_zero_slots();
        set_ring(32'd0, 32'h0000_1000);
        send_command(nfra_pkg::CMD_ALLOC, 16'h5555, 10'd0);
        send_command(nfra_pkg::CMD_LOOKUP, 16'h0000, 10'd0);
        send_command(nfra_pkg::CMD_RELEASE, 16'h0000, 10'd0);
    endtask

    // allocs most often, lookups and releases aimed at live slots, some clears and noise indexes
    task automatic test_random_ops(input int count, input logic [31:0] slots,
                                   input logic [31:0] base, input int tx_pct, input int rx_pct);
        int unsigned    roll;
        int unsigned    n;
        nfra_pkg::t_cmd cmd;
        logic [9:0]     idx;
        set_ring(slots, base);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        n = active_slots();
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 2) begin
                cmd = nfra_pkg::CMD_CLEAR;
            end else if (roll < 47) begin
                cmd = nfra_pkg::CMD_ALLOC;
            end else if (roll < 70) begin
                cmd = nfra_pkg::CMD_LOOKUP;
            end else begin
                cmd = nfra_pkg::CMD_RELEASE;
            end
            idx = 10'($urandom);
            if ($urandom_range(9) < 6 && recent_slots.size() > 0) begin
                idx = recent_slots[$urandom_range(recent_slots.size() - 1)];
            end else if (n > 0 && $urandom_range(9) < 7) begin
                idx = 10'($urandom_range(n - 1));
            end
            send_command(cmd, 16'($urandom), idx);
        end
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        set_ring(32'd1024, 32'h8000_0000);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(posedge i_clk);
        rx_hold_left = HOLD_CYCLES;
        for (int k = 0; k < 40; k++) begin
            send_command((k % 4 == 3) ? nfra_pkg::CMD_LOOKUP : nfra_pkg::CMD_ALLOC,
                         16'($urandom), 10'(k));
        end
    endtask

    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_replies
        t_reply want;
        t_reply got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status  = nfra_pkg::t_status'(m_axis_tuser[1:0]);
            got.present = m_axis_tuser[2];
            got.slot    = m_axis_tdata[9:0];
            got.addr    = m_axis_tdata[41:10];
            got.tag     = m_axis_tdata[57:42];
            if (pending_replies.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected reply status %0d slot %0d addr %h tag %h present %b",
                         $time, got.status, got.slot, got.addr, got.tag, got.present);
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.addr !== want.addr || got.tag !== want.tag ||
                    got.present !== want.present) begin
                    mismatches++;
                    $display("%0t: reply mismatch expected status %0d slot %0d addr %h tag %h present %b",
                             $time, want.status, want.slot, want.addr, want.tag, want.present);
                    $display("%0t:                  actual status %0d slot %0d addr %h tag %h present %b",
                             $time, got.status, got.slot, got.addr, got.tag, got.present);
                end
            end
        end
    end

    // cycles with no beat on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = nfra_pkg::CMD_ALLOC;
        m_axis_tready = 1'b0;
        slot_busy     = '{default: 1'b0};
        slot_owner    = '{default: 16'd0};
        fit_hint      = 0;
        cfg_slots     = nfra_pkg::RESET_NUM_SLOTS;
        cfg_base      = nfra_pkg::RESET_RING_BASE;
        mismatches    = 0;
        tx_idle_pct   = 26;
        rx_idle_pct   = 54;
        rx_hold_left  = 0;
        quiet_cycles  = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_small_ring();
        test_zero_slots();
        test_random_ops(160, 32'd37, 32'hffff_ff00, 26, 54);
        test_random_ops(170, 32'd2047, $urandom, 26, 54);
        test_random_ops(90, 32'd1, 32'h0000_0000, 54, 26);
        test_random_ops(200, 32'd100, 32'hffff_ffff, 54, 26);
        test_random_ops(30, 32'd0, $urandom, 0, 0);
        test_random_ops(250, 32'd64, $urandom, 0, 0);
        test_backpressure();

        wait_idle();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/nfra_pkg.sv
hw/rtl/nfra_occ_ram.sv
hw/rtl/nfra_tag_ram.sv
hw/rtl/nfra_ctrl.sv
hw/rtl/next_fit_ring_slot_allocator_core.sv
tb/next_fit_ring_slot_allocator_core_tb.sv
